@@ hdl/dmmd_pkg.sv @@
// Shared types and constants of the drive memory map decoder.
package dmmd_pkg;

    typedef struct packed {
        logic        req_type;
        logic [16:0] bus_address;
        logic [7:0]  write_byte;
    } t_req;

    typedef struct packed {
        logic [3:0]  target;
        logic [7:0]  read_byte;
        logic [14:0] rom_offset;
        logic [12:0] ram_offset;
        logic        device_strobe;
    } t_res;

    localparam logic [3:0] TGT_OPEN  = 4'd0;
    localparam logic [3:0] TGT_RAM   = 4'd1;
    localparam logic [3:0] TGT_ROM   = 4'd2;
    localparam logic [3:0] TGT_VIA1  = 4'd3;
    localparam logic [3:0] TGT_VIA2  = 4'd4;
    localparam logic [3:0] TGT_CIA   = 4'd5;
    localparam logic [3:0] TGT_FDC   = 4'd6;
    localparam logic [3:0] TGT_RIOT1 = 4'd7;
    localparam logic [3:0] TGT_RIOT2 = 4'd8;

    localparam logic [2:0] VAR_VIA0   = 3'd0;
    localparam logic [2:0] VAR_VIA1   = 3'd1;
    localparam logic [2:0] VAR_VIA2   = 3'd2;
    localparam logic [2:0] VAR_RIOT   = 3'd3;
    localparam logic [2:0] VAR_CIAVIA = 3'd4;
    localparam logic [2:0] VAR_CIARAM = 3'd5;

    localparam logic       REQ_READ  = 1'b0;
    localparam logic       REQ_WRITE = 1'b1;

    localparam int RAM_OFF_W = 13;

endpackage

@@ hdl/drive_memory_map_decoder_core.sv @@
// Top level of the drive memory map decoder with the local RAM.
// Result: each result is strobed on o_done in the cycle after its transfer is accepted.
// Throughput: one access per cycle while busy is low; the single-port RAM serves one access each cycle.
// Reset: synchronous, active low; the variant returns to zero and a clearing pass
// then zeroes all RAM_DEPTH entries, one entry a cycle, with busy held high.
// The receiver cannot stall; results must be taken in the cycle they appear.
module drive_memory_map_decoder_core #(
    parameter int RAM_DEPTH = 8192
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  dmmd_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_data,
    output logic          o_done,
    output dmmd_pkg::t_res o_res
);

    import dmmd_pkg::*;

    localparam int RAM_AW = $clog2(RAM_DEPTH);

    logic [2:0]        r_variant;
    logic              r_clr_busy;
    logic [RAM_AW-1:0] r_clr_addr;
    logic              r_done;
    logic              n_done;

    logic [3:0]        r_target, n_target;
    logic [7:0]        r_rd, n_rd;
    logic [14:0]       r_romo, n_romo;
    logic [RAM_AW-1:0] r_ramo, n_ramo;
    logic              r_strobe, n_strobe;
    logic              r_ram_rd, n_ram_rd;

    logic              accept;
    logic [15:0]       addr;
    logic [7:0]        page;
    logic [3:0]        dec_target;
    logic [RAM_AW-1:0] dec_idx;
    logic [15:0]       buf_idx;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    assign accept = start && !busy;
    assign busy   = r_clr_busy;
    assign addr   = i_req.bus_address[15:0];
    assign page   = addr[15:8];
    assign buf_idx = ((({2'b00, addr[15:2]}) & 16'h1c00) | (addr & 16'h03ff)) - 16'h0300;

    always_comb begin
        dec_target = TGT_OPEN;
        dec_idx    = '0;
        unique case (r_variant) inside
            VAR_RIOT: begin
                if (page >= 8'hC0) begin
                    dec_target = TGT_ROM;
                end else if (page >= 8'h10 && page <= 8'h50) begin
                    dec_target = TGT_RAM;
                    dec_idx    = buf_idx[RAM_AW-1:0];
                end else if (page < 8'h10) begin
                    if (!page[1]) begin
                        dec_target = TGT_RAM;
                        dec_idx    = RAM_AW'(addr[7:0]);
                    end else begin
                        dec_target = addr[7] ? TGT_RIOT2 : TGT_RIOT1;
                    end
                end
            end
            [VAR_VIA0:VAR_VIA2]: begin
                if (page >= 8'hC0) begin
                    dec_target = TGT_ROM;
                end else if (page < 8'h08) begin
                    dec_target = TGT_RAM;
                    dec_idx    = RAM_AW'(addr[12:0]);
                end else if (page >= 8'h18 && page < 8'h1C) begin
                    dec_target = TGT_VIA1;
                end else if (page >= 8'h1C && page < 8'h20) begin
                    dec_target = TGT_VIA2;
                end
            end
            VAR_CIAVIA: begin
                if (page >= 8'h80) begin
                    dec_target = TGT_ROM;
                end else if (page < 8'h08) begin
                    dec_target = TGT_RAM;
                    dec_idx    = RAM_AW'(addr[12:0]);
                end else if (page >= 8'h18 && page < 8'h1C) begin
                    dec_target = TGT_VIA1;
                end else if (page >= 8'h1C && page < 8'h20) begin
                    dec_target = TGT_VIA2;
                end else if (page >= 8'h40 && page < 8'h44) begin
                    dec_target = TGT_CIA;
                end else if (page >= 8'h20 && page < 8'h24) begin
                    dec_target = TGT_FDC;
                end
            end
            VAR_CIARAM: begin
                if (page >= 8'h80) begin
                    dec_target = TGT_ROM;
                end else if (page < 8'h20) begin
                    dec_target = TGT_RAM;
                    dec_idx    = RAM_AW'(addr[12:0]);
                end else if (page >= 8'h40 && page < 8'h44) begin
                    dec_target = TGT_CIA;
                end else if (page >= 8'h60 && page < 8'h64) begin
                    dec_target = TGT_FDC;
                end
            end
            default: begin
                if (page < 8'h08) begin
                    dec_target = TGT_RAM;
                    dec_idx    = RAM_AW'(addr[12:0]);
                end
            end
        endcase
    end

    always_comb begin
        n_done   = accept;
        n_target = dec_target;
        n_rd     = '0;
        n_romo   = '0;
        n_ramo   = '0;
        n_strobe = 1'b0;
        n_ram_rd = 1'b0;
        unique case (dec_target)
            TGT_RAM: begin
                n_ramo   = dec_idx;
                n_ram_rd = (i_req.req_type == REQ_READ);
            end
            TGT_ROM: begin
                if (i_req.req_type == REQ_WRITE) begin
                    n_target = TGT_OPEN;
                end else begin
                    n_romo = addr[14:0];
                end
            end
            TGT_OPEN: begin
                if (i_req.req_type == REQ_READ) begin
                    n_rd = page;
                end
            end
            default: begin
                n_strobe = 1'b1;
            end
        endcase
    end

    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_addr  = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = accept && (dec_target == TGT_RAM) && (i_req.req_type == REQ_WRITE);
            ram_addr  = dec_idx;
            ram_wdata = i_req.write_byte;
        end
    end

    dmmd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant  <= VAR_VIA0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_variant <= i_cfg_data;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == RAM_AW'(RAM_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_target <= n_target;
            r_rd     <= n_rd;
            r_romo   <= n_romo;
            r_ramo   <= n_ramo;
            r_strobe <= n_strobe;
            r_ram_rd <= n_ram_rd;
        end
    end

    assign o_done              = r_done;
    assign o_res.target        = r_target;
    assign o_res.read_byte     = r_ram_rd ? ram_rdata : r_rd;
    assign o_res.rom_offset    = r_romo;
    assign o_res.ram_offset    = RAM_OFF_W'(r_ramo);
    assign o_res.device_strobe = r_strobe;

endmodule

@@ hdl/dmmd_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
module dmmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ dv/drive_memory_map_decoder_core_tb.sv @@
// Self-checking testbench of the drive memory map decoder core with its local RAM.
module drive_memory_map_decoder_core_tb;

    import dmmd_pkg::*;

    localparam logic [2:0] VAR_RSVD6 = 3'd6;
    localparam logic [2:0] VAR_RSVD7 = 3'd7;
    localparam int RAM_WORDS = 8192;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 163;

    class decode_checker;
        logic [2:0] variant;
        bit [7:0]   ram_image [RAM_WORDS];
        t_res       pending_results [$];
        int         errors;
        int         checked;
        int         accepted;
        int         writes;

        function new();
            variant = VAR_VIA0;
            errors = 0;
            checked = 0;
            accepted = 0;
            writes = 0;
        endfunction

        function logic [3:0] map_page(input logic [15:0] a, output logic [12:0] idx);
            logic [7:0]  pg;
            logic [15:0] buf_lin;
            pg = a[15:8];
            idx = '0;
            if (variant == VAR_RIOT) begin
                if (pg >= 8'hC0) return TGT_ROM;
                if (pg >= 8'h10 && pg <= 8'h50) begin
                    buf_lin = (((a >> 2) & 16'h1C00) | (a & 16'h03FF)) - 16'h0300;
                    idx = buf_lin[12:0];
                    return TGT_RAM;
                end
                if (pg < 8'h10) begin
                    if (!pg[1]) begin
                        idx = {5'd0, a[7:0]};
                        return TGT_RAM;
                    end
                    return a[7] ? TGT_RIOT2 : TGT_RIOT1;
                end
                return TGT_OPEN;
            end
            if (variant <= VAR_VIA2 && pg >= 8'hC0) return TGT_ROM;
            if ((variant == VAR_CIAVIA || variant == VAR_CIARAM) && pg >= 8'h80) return TGT_ROM;
            if (pg < 8'h08 || (variant == VAR_CIARAM && pg < 8'h20)) begin
                idx = a[12:0];
                return TGT_RAM;
            end
            if (variant <= VAR_VIA2 || variant == VAR_CIAVIA) begin
                if (pg >= 8'h18 && pg < 8'h1C) return TGT_VIA1;
                if (pg >= 8'h1C && pg < 8'h20) return TGT_VIA2;
            end
            if (variant == VAR_CIAVIA) begin
                if (pg >= 8'h40 && pg < 8'h44) return TGT_CIA;
                if (pg >= 8'h20 && pg < 8'h24) return TGT_FDC;
            end
            if (variant == VAR_CIARAM) begin
                if (pg >= 8'h40 && pg < 8'h44) return TGT_CIA;
                if (pg >= 8'h60 && pg < 8'h64) return TGT_FDC;
            end
            return TGT_OPEN;
        endfunction

        function void note_access(input t_req r);
            t_res        exp;
            logic [15:0] a;
            logic [12:0] idx;
            logic        is_wr;
            a = r.bus_address[15:0];
            is_wr = (r.req_type == REQ_WRITE);
            exp = '0;
            exp.target = map_page(a, idx);
            accepted++;
            if (is_wr) writes++;
            case (exp.target)
                TGT_RAM: begin
                    exp.ram_offset = idx;
                    if (is_wr) ram_image[idx] = r.write_byte;
                    else exp.read_byte = ram_image[idx];
                end
                TGT_ROM: begin
                    if (is_wr) exp.target = TGT_OPEN;
                    else exp.rom_offset = a[14:0];
                end
                TGT_OPEN: begin
                    if (!is_wr) exp.read_byte = a[15:8];
                end
                default: begin
                    exp.device_strobe = 1'b1;
                end
            endcase
            pending_results.push_back(exp);
        endfunction

        function void compare_field(input string name, input logic [31:0] e,
                                    input logic [31:0] a);
            if (a !== e) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
            end
        endfunction

        function void check_result(input t_res got);
            t_res exp;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
                return;
            end
            exp = pending_results.pop_front();
            checked++;
            compare_field("target", 32'(exp.target), 32'(got.target));
            compare_field("read_byte", 32'(exp.read_byte), 32'(got.read_byte));
            compare_field("rom_offset", 32'(exp.rom_offset), 32'(got.rom_offset));
            compare_field("ram_offset", 32'(exp.ram_offset), 32'(got.ram_offset));
            compare_field("device_strobe", 32'(exp.device_strobe), 32'(got.device_strobe));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_data;
    logic        o_done;
    t_res        o_res;

    decode_checker   sb;
    logic [16:0]     recent_writes [$];
    logic            idle_enabled;
    int              settings_run;
    int              cycle_count;
    logic [2:0]      plan [10];

    drive_memory_map_decoder_core #(
        .RAM_DEPTH(RAM_WORDS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_done(o_done),
        .o_res(o_res)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (o_done === 1'b1) sb.check_result(o_res);
        if (i_rst_n && start && busy === 1'b0) sb.note_access(i_req);
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge i_clk);
        $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic apply_access(input logic typ, input logic [16:0] addr,
                                input logic [7:0] data);
        if (idle_enabled && $urandom_range(0, 99) < 10) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start = 1'b1;
        i_req = '{req_type: typ, bus_address: addr, write_byte: data};
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_variant(input logic [2:0] v);
        wait_for_results();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.variant = v;
        settings_run++;
    endtask

    function automatic logic [16:0] pick_address();
        logic [16:0] a;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        a = 17'($urandom);
        if (sel < 25 && recent_writes.size() > 0)
            return recent_writes[$urandom_range(0, recent_writes.size() - 1)];
        if (sel < 88) begin
            a[16] = ($urandom_range(0, 15) == 0);
            if (sel < 50) a[15:8] = 8'($urandom_range(8'h00, 8'h1F));
            else if (sel < 70) a[15:8] = 8'($urandom_range(8'h20, 8'h64));
            else a[15:8] = 8'($urandom_range(8'h80, 8'hFF));
        end
        return a;
    endfunction

    task automatic random_access();
        logic        typ;
        logic [16:0] addr;
        typ = ($urandom_range(0, 99) < 40) ? REQ_WRITE : REQ_READ;
        addr = pick_address();
        if (typ == REQ_WRITE) begin
            recent_writes.push_back(addr);
            if (recent_writes.size() > 32) void'(recent_writes.pop_front());
        end
        apply_access(typ, addr, 8'($urandom));
    endtask

    initial begin
        start = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        idle_enabled = 1'b1;
        settings_run = 0;
        sb = new();
        plan = '{VAR_RIOT, VAR_CIAVIA, VAR_VIA1, VAR_CIARAM, VAR_RSVD7,
                 VAR_VIA2, VAR_RIOT, VAR_RSVD6, VAR_VIA0, VAR_CIARAM};
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);

        set_variant(VAR_VIA0);
        apply_access(REQ_READ,  17'h00000, 8'h00);
        apply_access(REQ_WRITE, 17'h007FF, 8'hFF);
        apply_access(REQ_READ,  17'h007FF, 8'h00);
        apply_access(REQ_WRITE, 17'h10005, 8'hAA);
        apply_access(REQ_READ,  17'h00005, 8'hFF);
        apply_access(REQ_READ,  17'h10000, 8'h00);
        apply_access(REQ_READ,  17'h01800, 8'h00);
        apply_access(REQ_WRITE, 17'h01BFF, 8'h5A);
        apply_access(REQ_READ,  17'h01C00, 8'h00);
        apply_access(REQ_WRITE, 17'h01FFF, 8'hA5);
        apply_access(REQ_READ,  17'h0C000, 8'h00);
        apply_access(REQ_READ,  17'h1FFFF, 8'h00);
        apply_access(REQ_WRITE, 17'h0FFFF, 8'h33);
        apply_access(REQ_READ,  17'h00800, 8'h00);
        apply_access(REQ_WRITE, 17'h0BFFF, 8'hC3);
        apply_access(REQ_READ,  17'h0BF80, 8'h00);
        apply_access(REQ_WRITE, 17'h00123, 8'h55);
        apply_access(REQ_READ,  17'h00123, 8'h00);

        for (int ph = 0; ph < 10; ph++) begin
            set_variant(plan[ph]);
            idle_enabled = (ph != 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 4 && k == PHASE_ITEMS / 2) wait_for_results();
                random_access();
            end
        end

        wait_for_results();
        repeat (3) @(posedge i_clk);
        $display("Run covered %0d bus transfers (%0d writes) over %0d variant settings,",
                 sb.accepted, sb.writes, settings_run);
        $display("including reserved variants, page aliasing and RAM read-back; %0d results checked.",
                 sb.checked);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches found", sb.errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
